// File: design/wss_pkg.sv
// Shared types and constants for the windowed stream splitter.
package wss_pkg;

  localparam int SAMPLE_W = 24;
  localparam int WEIGHT_W = 17;
  localparam int INDEX_W  = 10;
  localparam int LENGTH_W = 11;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam int DEF_CHANNEL_COUNT = 2;
  localparam int DEF_WINDOW_DEPTH  = 1024;

  localparam logic [WEIGHT_W-1:0] UNITY_WEIGHT = 17'd65536;
  localparam logic [LENGTH_W-1:0] LENGTH_RESET = 11'd1024;

  // command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  // split modes
  localparam logic MODE_GATE  = 1'b0;
  localparam logic MODE_XFADE = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_SPLIT_MODE    = 1'b0;
  localparam logic REG_WINDOW_LENGTH = 1'b1;

  typedef struct packed {
    logic                split_mode;
    logic [LENGTH_W-1:0] window_length;
  } cfg_t;

  // item between the phase stage and the weighting stage
  typedef struct packed {
    logic                       valid;
    logic                       channel;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       mode;
    logic                       first_half;
  } stage_t;

endpackage

// File: design/wss_if.sv
// Item channel interfaces: input items and result items.
interface wss_feed_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic                                channel;
  logic signed [wss_pkg::SAMPLE_W-1:0] sample;
  logic [wss_pkg::INDEX_W-1:0]         entry_index;
  logic [wss_pkg::WEIGHT_W-1:0]        entry_value;

  modport source (output valid, command, channel, sample, entry_index, entry_value,
                  input ready);
  modport sink (input valid, command, channel, sample, entry_index, entry_value,
                output ready);
endinterface

interface wss_result_if;
  logic                                valid;
  logic                                ready;
  logic                                out_channel;
  logic signed [wss_pkg::SAMPLE_W-1:0] first_out;
  logic signed [wss_pkg::SAMPLE_W-1:0] second_out;

  modport source (output valid, out_channel, first_out, second_out, input ready);
  modport sink (input valid, out_channel, first_out, second_out, output ready);
endinterface

// File: design/wss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/wss_cfg.sv
// APB register file: split mode and window length.
module wss_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [wss_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [wss_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [wss_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output wss_pkg::cfg_t                    cfg
);
  import wss_pkg::*;

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.split_mode    <= MODE_GATE;
      cfg.window_length <= LENGTH_RESET;
    end else if (wr) begin
      unique case (paddr[2])
        REG_SPLIT_MODE:    cfg.split_mode    <= pwdata[0];
        REG_WINDOW_LENGTH: cfg.window_length <= pwdata[LENGTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SPLIT_MODE:    prdata = APB_DATA_W'(cfg.split_mode);
      REG_WINDOW_LENGTH: prdata = APB_DATA_W'(cfg.window_length);
      default:           prdata = '0;
    endcase
  end

endmodule

// File: design/wss_front.sv
// Input stage: phase counters, table load and read address, stage register.
module wss_front #(
  parameter int CHANNEL_COUNT = wss_pkg::DEF_CHANNEL_COUNT,
  parameter int WINDOW_DEPTH  = wss_pkg::DEF_WINDOW_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  wss_feed_if.sink                          feed,
  input  wss_pkg::cfg_t                     cfg,
  input  logic                              advance,
  output logic                              ram_we,
  output logic [$clog2(WINDOW_DEPTH)-1:0]   ram_waddr,
  output logic [wss_pkg::WEIGHT_W-1:0]      ram_wdata,
  output logic [$clog2(WINDOW_DEPTH)-1:0]   ram_raddr,
  output wss_pkg::stage_t                   stage
);
  import wss_pkg::*;

  localparam int PHASE_W  = $clog2(WINDOW_DEPTH);
  localparam int LEN_W    = $clog2(WINDOW_DEPTH + 1);
  localparam int CMP_W    = (LEN_W > LENGTH_W) ? LEN_W : LENGTH_W;
  localparam int IDXC_W   = (LEN_W > INDEX_W) ? LEN_W : INDEX_W;
  localparam int CH_IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam logic CH1_OK = (CHANNEL_COUNT > 1);

  logic [PHASE_W-1:0]  phase [CHANNEL_COUNT];
  logic [PHASE_W-1:0]  cur;
  logic [PHASE_W-1:0]  phase_next;
  logic [CH_IDX_W-1:0] ch_idx;
  logic [CMP_W-1:0]    len_raw;
  logic [CMP_W-1:0]    eff_len;
  logic [CMP_W-1:0]    cur_ext;
  logic [CMP_W-1:0]    cur_inc;
  logic                take;
  logic                ch_ok;
  logic                is_sample;

  assign feed.ready = advance;
  assign take       = feed.valid && advance;
  assign ch_idx     = CH_IDX_W'(feed.channel);
  assign ch_ok      = (feed.channel == 1'b0) || CH1_OK;
  assign is_sample  = take && (feed.command == CMD_SAMPLE) && ch_ok;
  assign cur        = phase[ch_idx];

  always_comb begin
    len_raw = CMP_W'(cfg.window_length);
    if (len_raw < CMP_W'(2)) begin
      eff_len = CMP_W'(2);
    end else if (len_raw > CMP_W'(WINDOW_DEPTH)) begin
      eff_len = CMP_W'(WINDOW_DEPTH);
    end else begin
      eff_len = len_raw;
    end
    cur_ext = CMP_W'(cur);
    cur_inc = cur_ext + CMP_W'(1);
    // a phase left past a shortened window still wraps to zero
    phase_next = (cur_inc >= eff_len) ? '0 : PHASE_W'(cur_inc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        phase[i] <= '0;
      end
    end else if (is_sample) begin
      phase[ch_idx] <= phase_next;
    end
  end

  // table load, out-of-table indexes dropped, weights clamped to unity
  assign ram_we    = take && (feed.command == CMD_LOAD)
                     && (IDXC_W'(feed.entry_index) < IDXC_W'(WINDOW_DEPTH));
  assign ram_waddr = PHASE_W'(feed.entry_index);
  assign ram_wdata = (feed.entry_value > UNITY_WEIGHT) ? UNITY_WEIGHT : feed.entry_value;
  assign ram_raddr = cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (advance) begin
      stage.valid <= is_sample;
    end
    if (advance) begin
      stage.channel    <= feed.channel;
      stage.sample     <= feed.sample;
      stage.mode       <= cfg.split_mode;
      stage.first_half <= cur_ext < (eff_len >> 1);
    end
  end

endmodule

// File: design/wss_back.sv
// Weighting stage: gate or crossfade products into the result register.
module wss_back (
  input  logic                         clk,
  input  logic                         rst,
  input  wss_pkg::stage_t              stage,
  input  logic [wss_pkg::WEIGHT_W-1:0] weight,
  output logic                         advance,
  wss_result_if.source                 result
);
  import wss_pkg::*;

  localparam int PROD_W = SAMPLE_W + WEIGHT_W + 1;

  logic                       out_adv;
  logic [WEIGHT_W-1:0]        weight_inv;
  logic signed [PROD_W-1:0]   prod_a;
  logic signed [PROD_W-1:0]   prod_b;
  logic signed [SAMPLE_W-1:0] first_v;
  logic signed [SAMPLE_W-1:0] second_v;

  assign out_adv = !result.valid || result.ready;
  assign advance = !stage.valid || out_adv;

  assign weight_inv = UNITY_WEIGHT - weight;
  assign prod_a     = stage.sample * $signed({1'b0, weight});
  assign prod_b     = stage.sample * $signed({1'b0, weight_inv});

  always_comb begin
    unique case (stage.mode)
      MODE_XFADE: begin
        // arithmetic shift of the product: floor rounding
        first_v  = prod_a[SAMPLE_W+15:16];
        second_v = prod_b[SAMPLE_W+15:16];
      end
      MODE_GATE: begin
        first_v  = stage.first_half ? stage.sample : '0;
        second_v = stage.first_half ? '0 : stage.sample;
      end
      default: begin
        first_v  = '0;
        second_v = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_adv) begin
      result.valid <= stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && stage.valid) begin
      result.out_channel <= stage.channel;
      result.first_out   <= first_v;
      result.second_out  <= second_v;
    end
  end

endmodule

// File: design/windowed_stream_splitter.sv
// Top level of the windowed stream splitter.
//
// Input items on feed: command selects a sample item or a window-table load.
// A sample item for a channel below CHANNEL_COUNT gives one result item on
// result (channel, first output, second output); load items and samples of
// other channels give none. Each channel keeps a phase counter that wraps at
// the configured window length. Gate mode routes the first half of a window to
// the first output; crossfade mode scales by table weight w and by 1 - w.
// Throughput is one item per cycle while the receiver takes results: the
// table RAM has one write and one registered read port and each item uses
// one of them once. Two register stages (phase/read stage, result register)
// let a new item enter while a result waits to be taken. When the receiver
// stalls, the result register holds, the middle stage fills, and only then
// does feed.ready drop. Reset clears the phase counters, the valid bits and
// the registers (gate mode, window length 1024); the weight table is not
// cleared and must be loaded before crossfade mode reads it. The user writes
// configuration through the APB port while the block is idle (not enforced).
module windowed_stream_splitter #(
  parameter int CHANNEL_COUNT = wss_pkg::DEF_CHANNEL_COUNT,
  parameter int WINDOW_DEPTH  = wss_pkg::DEF_WINDOW_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  wss_feed_if.sink                       feed,
  wss_result_if.source                   result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wss_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [wss_pkg::APB_DATA_W-1:0] pwdata,
  output logic [wss_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import wss_pkg::*;

  localparam int ADDR_W = $clog2(WINDOW_DEPTH);

  cfg_t                cfg;
  stage_t              stage;
  logic                advance;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [WEIGHT_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [WEIGHT_W-1:0] weight;

  wss_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wss_front #(
    .CHANNEL_COUNT (CHANNEL_COUNT),
    .WINDOW_DEPTH  (WINDOW_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .feed      (feed),
    .cfg       (cfg),
    .advance   (advance),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .stage     (stage)
  );

  // read data holds while the middle stage is stalled
  wss_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_weights (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (advance),
    .raddr (ram_raddr),
    .rdata (weight)
  );

  wss_back u_back (
    .clk     (clk),
    .rst     (rst),
    .stage   (stage),
    .weight  (weight),
    .advance (advance),
    .result  (result)
  );

endmodule

// File: design/wss_checker.sv
// Port-level checker for the windowed stream splitter, bound to the top level.
module wss_checker (
  input logic clk,
  input logic rst,
  input logic feed_valid,
  input logic feed_ready,
  input logic result_valid,
  input logic result_ready
);

  // a pending result stays offered until taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result dropped before it was taken");

  // input is refused only while a result is stuck at the output
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !feed_ready |-> result_valid && !result_ready)
    else $error("input stalled without an output stall");

  // a fresh result follows an accepted item that passed through the stage register
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(feed_valid && feed_ready, 2))
    else $error("result without an accepted item");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind windowed_stream_splitter wss_checker u_wss_checker (
  .clk          (clk),
  .rst          (rst),
  .feed_valid   (feed.valid),
  .feed_ready   (feed.ready),
  .result_valid (result.valid),
  .result_ready (result.ready)
);

// File: sim/testbench.sv
// Self-checking testbench for the windowed stream splitter: directed and random items.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import wss_pkg::*;

  localparam int RANDOM_ITEMS = 1700;
  localparam int SETTLE_CYCLES = 4;

  typedef struct {
    logic                       command;
    logic                       channel;
    logic signed [SAMPLE_W-1:0] sample;
    logic [INDEX_W-1:0]         entry_index;
    logic [WEIGHT_W-1:0]        entry_value;
  } feed_item_t;

  typedef struct {
    logic                out_channel;
    logic [SAMPLE_W-1:0] first_out;
    logic [SAMPLE_W-1:0] second_out;
  } split_result_t;

  // Splitter state mirror plus the queue of results still owed by the block.
  class split_scoreboard;
    logic                mode;
    logic [LENGTH_W-1:0] length_reg;
    int unsigned         phase [DEF_CHANNEL_COUNT];
    logic [WEIGHT_W-1:0] weights [DEF_WINDOW_DEPTH];
    bit                  loaded [DEF_WINDOW_DEPTH];
    split_result_t       owed [$];
    int                  errors;

    function new();
      mode = MODE_GATE;
      length_reg = LENGTH_RESET;
      foreach (phase[i]) phase[i] = 0;
      foreach (loaded[i]) loaded[i] = 1'b0;
      errors = 0;
    endfunction

    // out-of-range lengths clamp to 2 .. table depth
    function int unsigned span_of(logic [LENGTH_W-1:0] length);
      if (length < 2) return 2;
      if (length > DEF_WINDOW_DEPTH) return DEF_WINDOW_DEPTH;
      return 32'(length);
    endfunction

    function void write_reg(logic idx, logic [APB_DATA_W-1:0] value);
      if (idx == REG_SPLIT_MODE) mode = value[0];
      else length_reg = value[LENGTH_W-1:0];
    endfunction

    // floor((s * w) / 65536), kept to the sample width
    function logic [SAMPLE_W-1:0] scale(logic signed [SAMPLE_W-1:0] s, logic [WEIGHT_W-1:0] w);
      logic signed [SAMPLE_W+WEIGHT_W:0] prod;
      prod = s * $signed({1'b0, w});
      return prod[SAMPLE_W+15:16];
    endfunction

    function void note_item(feed_item_t it);
      split_result_t exp;
      int unsigned   len;
      int unsigned   p;
      logic [WEIGHT_W-1:0] w;
      if (it.command == CMD_LOAD) begin
        weights[it.entry_index] = (it.entry_value > UNITY_WEIGHT) ? UNITY_WEIGHT : it.entry_value;
        loaded[it.entry_index] = 1'b1;
        return;
      end
      len = span_of(length_reg);
      p = phase[it.channel];
      exp.out_channel = it.channel;
      if (mode == MODE_GATE) begin
        exp.first_out = (p < len / 2) ? it.sample : '0;
        exp.second_out = (p < len / 2) ? '0 : it.sample;
      end else begin
        w = weights[p];
        exp.first_out = scale(it.sample, w);
        exp.second_out = scale(it.sample, UNITY_WEIGHT - w);
      end
      phase[it.channel] = (p + 1 >= len) ? 0 : p + 1;
      owed.push_back(exp);
    endfunction

    function void check_result(split_result_t got);
      split_result_t exp;
      if (owed.size() == 0) begin
        $error("unexpected result: channel %0d first %0d second %0d",
               got.out_channel, $signed(got.first_out), $signed(got.second_out));
        errors++;
        return;
      end
      exp = owed.pop_front();
      if (got.out_channel !== exp.out_channel) begin
        $error("out_channel: expected %0d, got %0d", exp.out_channel, got.out_channel);
        errors++;
      end
      if (got.first_out !== exp.first_out) begin
        $error("first_out: expected %0d, got %0d", $signed(exp.first_out), $signed(got.first_out));
        errors++;
      end
      if (got.second_out !== exp.second_out) begin
        $error("second_out: expected %0d, got %0d", $signed(exp.second_out),
               $signed(got.second_out));
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  wss_feed_if feed_bus ();
  wss_result_if result_bus ();

  split_scoreboard sb = new();

  int stall_style;
  int stall_left;
  int unsigned cycle_count;
  int sent;

  windowed_stream_splitter i_dut (
    .clk     (clk),
    .rst     (rst),
    .feed    (feed_bus),
    .result  (result_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("windowed_stream_splitter: mismatch");
    $finish;
  end

  function automatic feed_item_t sample_item(logic ch, logic [SAMPLE_W-1:0] s);
    feed_item_t it;
    it.command = CMD_SAMPLE;
    it.channel = ch;
    it.sample = s;
    it.entry_index = INDEX_W'($urandom());
    it.entry_value = WEIGHT_W'($urandom());
    return it;
  endfunction

  function automatic feed_item_t load_item(logic [INDEX_W-1:0] idx, logic [WEIGHT_W-1:0] val);
    feed_item_t it;
    it.command = CMD_LOAD;
    it.channel = 1'($urandom_range(0, 1));
    it.sample = SAMPLE_W'($urandom());
    it.entry_index = idx;
    it.entry_value = val;
    return it;
  endfunction

  function automatic logic [WEIGHT_W-1:0] random_weight();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return UNITY_WEIGHT;
      2: return WEIGHT_W'($urandom_range(65537, 131071));
      default: return WEIGHT_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic feed_item_t random_item();
    logic [SAMPLE_W-1:0] s;
    case ($urandom_range(0, 9))
      0: s = 24'h800000;
      1: s = 24'h7FFFFF;
      2: s = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
      default: s = SAMPLE_W'($urandom());
    endcase
    if ($urandom_range(0, 99) < 15) return load_item(INDEX_W'($urandom()), random_weight());
    return sample_item(1'($urandom_range(0, 1)), s);
  endfunction

  function automatic logic [LENGTH_W-1:0] random_length();
    case ($urandom_range(0, 7))
      0: return LENGTH_W'($urandom_range(0, 1));
      1: return LENGTH_W'($urandom_range(2, 4));
      2, 3: return LENGTH_W'($urandom_range(5, 40));
      4: return LENGTH_W'($urandom_range(41, 300));
      5: return LENGTH_W'($urandom_range(1023, 1024));
      6: return LENGTH_W'($urandom_range(1025, 2047));
      default: return LENGTH_W'($urandom_range(2, 1024));
    endcase
  endfunction

  // Leaves valid high on return so a following item goes out back to back.
  task automatic push(feed_item_t it);
    feed_bus.valid <= 1'b1;
    feed_bus.command <= it.command;
    feed_bus.channel <= it.channel;
    feed_bus.sample <= it.sample;
    feed_bus.entry_index <= it.entry_index;
    feed_bus.entry_value <= it.entry_value;
    do @(posedge clk); while (!feed_bus.ready);
    sb.note_item(it);
    sent++;
  endtask

  // Loads leave nothing in the queue, so also let the pipe settle after it empties.
  task automatic wait_drained();
    feed_bus.valid <= 1'b0;
    do @(posedge clk); while (sb.owed.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(logic idx, logic [APB_DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, value);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Crossfade must never read an unloaded weight: fill every entry the new
  // window reaches, plus any phase still parked past its end.
  task automatic set_config(logic mode, logic [LENGTH_W-1:0] length);
    int unsigned len;
    bit filled;
    filled = 1'b0;
    wait_drained();
    if (mode == MODE_XFADE) begin
      len = sb.span_of(length);
      for (int i = 0; i < DEF_WINDOW_DEPTH; i++) begin
        if ((i < len || i == sb.phase[0] || i == sb.phase[1]) && !sb.loaded[i]) begin
          push(load_item(INDEX_W'(i), random_weight()));
          filled = 1'b1;
        end
      end
      if (filled) wait_drained();
    end
    apb_write(REG_SPLIT_MODE, {{(APB_DATA_W-1){1'b0}}, mode});
    apb_write(REG_WINDOW_LENGTH, {{(APB_DATA_W-LENGTH_W){1'b0}}, length});
  endtask

  // receiver: checks each accepted result, stalls in changing styles
  initial begin
    result_bus.ready <= 1'b0;
    stall_style = 0;
    stall_left = 0;
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (!rst && result_bus.valid && result_bus.ready)
        sb.check_result('{result_bus.out_channel, result_bus.first_out, result_bus.second_out});
      if (stall_left == 0) begin
        stall_style = $urandom_range(0, 3);
        stall_left = $urandom_range(32, 256);
      end else begin
        stall_left--;
      end
      case (stall_style)
        0: result_bus.ready <= 1'b1;
        1: result_bus.ready <= 1'($urandom_range(0, 1));
        2: result_bus.ready <= ($urandom_range(0, 3) == 0);
        default: result_bus.ready <= (cycle_count[2:1] != 2'b11);
      endcase
    end
  end

  initial begin
    int round_items;
    int burst;
    int gap;
    logic mode;
    logic [LENGTH_W-1:0] length;

    rst <= 1'b1;
    feed_bus.valid <= 1'b0;
    feed_bus.command <= CMD_SAMPLE;
    feed_bus.channel <= 1'b0;
    feed_bus.sample <= '0;
    feed_bus.entry_index <= '0;
    feed_bus.entry_value <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // gate mode at reset length, sample extremes
    push(sample_item(0, 24'h800000));
    push(sample_item(0, 24'h7FFFFF));
    push(sample_item(0, 24'h000000));
    push(sample_item(0, 24'hFFFFFF));
    push(sample_item(1, 24'h7FFFFF));
    // weights: above unity clamps, zero, half, unity, last entry
    push(load_item(0, 17'h1FFFF));
    push(load_item(1, 17'd0));
    push(load_item(2, 17'd32768));
    push(load_item(3, UNITY_WEIGHT));
    push(load_item(1023, 17'd1));
    // length below 2; channel 0 sits past the end of the new window
    set_config(MODE_GATE, 1);
    push(sample_item(0, 24'h123456));
    push(sample_item(0, 24'hABCDEF));
    push(sample_item(1, 24'h000001));
    set_config(MODE_XFADE, 4);
    push(sample_item(0, 24'h800000));
    push(sample_item(0, 24'h7FFFFF));
    push(sample_item(0, 24'hFFFFFF));
    push(sample_item(0, 24'h000001));
    push(sample_item(0, 24'h000123));
    push(sample_item(1, 24'h800000));

    sent = 0;
    for (int round = 0; sent < RANDOM_ITEMS; round++) begin
      case (round)
        0: begin mode = MODE_GATE; length = 2047; end
        1: begin mode = MODE_XFADE; length = 0; end
        2: begin mode = MODE_XFADE; length = 1024; end
        3: begin mode = MODE_GATE; length = 3; end
        4: begin mode = MODE_XFADE; length = 2047; end
        5: begin mode = MODE_XFADE; length = 2; end
        default: begin mode = 1'($urandom_range(0, 1)); length = random_length(); end
      endcase
      set_config(mode, length);
      round_items = $urandom_range(60, 160);
      while (round_items > 0 && sent < RANDOM_ITEMS) begin
        burst = $urandom_range(1, 16);
        for (int k = 0; k < burst && round_items > 0; k++) begin
          push(random_item());
          round_items--;
        end
        if ($urandom_range(0, 29) == 0) begin
          wait_drained();
        end else begin
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
          if (gap > 0) begin
            feed_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
      end
    end

    wait_drained();
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("windowed_stream_splitter: match");
    end else begin
      $display("windowed_stream_splitter: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/wss_pkg.sv
design/wss_if.sv
design/wss_ram.sv
design/wss_cfg.sv
design/wss_front.sv
design/wss_back.sv
design/windowed_stream_splitter.sv
design/wss_checker.sv
sim/testbench.sv
